### src/sliding_window_maximum_core_assert.svh
// ----------------------------------------------------------------------------
// sliding window maximum assertion macros
// shared concurrent property forms for the core's checks
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAXIMUM_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SWM_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sliding window maximum check failed");

// next-cycle implication, disabled during reset
`define SWM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sliding window maximum check failed");

`endif

### src/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int WINDOW_MAX_DEFAULT  = 64;
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int POS_BITS            = 16;
   localparam int CFG_BITS            = 7;

   localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RESET = 7'd1;

   // controller to datapath
   typedef struct packed {
      logic take;        // latch the accepted transaction
      logic rd_back;     // queue read address: back entry instead of front
      logic drop_front;  // front entry has slid out of the window
      logic drop_back;   // back entry is not greater than the new sample
      logic push;        // append the new sample at the back
      logic load_out;    // load the front value into the output register
   } swm_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic queue_empty;
      logic front_expired;
      logic back_le;
      logic result_due;
      logic out_free;
   } swm_status_type;

endpackage

### src/swm_ram.sv
// ----------------------------------------------------------------------------
// swm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/swm_ctrl.sv
// ----------------------------------------------------------------------------
// swm_ctrl
// sequencer: expire from the front, pop from the back, push, read the front
// ----------------------------------------------------------------------------
module swm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  swm_pkg::swm_status_type status,
   output swm_pkg::swm_cmd_type    cmd
);

   import swm_pkg::*;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_EXP_RD    = 3'd1;
   localparam logic [2:0] ST_EXP_CHK   = 3'd2;
   localparam logic [2:0] ST_POP_RD    = 3'd3;
   localparam logic [2:0] ST_POP_CHK   = 3'd4;
   localparam logic [2:0] ST_WRITE     = 3'd5;
   localparam logic [2:0] ST_FRONT_RD  = 3'd6;
   localparam logic [2:0] ST_FRONT_OUT = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = ST_EXP_RD;
            end
         end
         ST_EXP_RD: begin
            // front address goes to the ram here
            state_in = status.queue_empty ? ST_WRITE : ST_EXP_CHK;
         end
         ST_EXP_CHK: begin
            if (status.front_expired) begin
               cmd.drop_front = 1'b1;
               state_in       = ST_EXP_RD;
            end else begin
               state_in = ST_POP_RD;
            end
         end
         ST_POP_RD: begin
            cmd.rd_back = 1'b1;
            state_in    = status.queue_empty ? ST_WRITE : ST_POP_CHK;
         end
         ST_POP_CHK: begin
            if (status.back_le) begin
               cmd.drop_back = 1'b1;
               state_in      = ST_POP_RD;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.push = 1'b1;
            state_in = ST_FRONT_RD;
         end
         ST_FRONT_RD: begin
            state_in = status.result_due ? ST_FRONT_OUT : ST_IDLE;
         end
         ST_FRONT_OUT: begin
            // hold the front address so the read data stays put while stalled
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

### src/swm_dp.sv
// ----------------------------------------------------------------------------
// swm_dp
// queue ram, head and occupancy, position, fill count and output register
// ----------------------------------------------------------------------------
`include "sliding_window_maximum_core_assert.svh"

module swm_dp #(
   parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [swm_pkg::CFG_BITS-1:0]  csr_wr_data,
   input  logic [SAMPLE_BITS-1:0]        req_sample,
   input  logic                          req_start,
   input  logic                          req_end,
   input  logic                          rsp_tready,
   output logic                          rsp_valid,
   output logic [SAMPLE_BITS-1:0]        rsp_sample,
   output logic                          rsp_last,
   input  swm_pkg::swm_cmd_type          cmd,
   output swm_pkg::swm_status_type       status
);

   import swm_pkg::*;

   localparam int AW = $clog2(WINDOW_MAX);
   localparam int OW = $clog2(WINDOW_MAX + 1);
   localparam int SW = OW + 1;
   localparam int EW = SAMPLE_BITS + POS_BITS;

   localparam logic [POS_BITS-1:0] WMAX_POS  = POS_BITS'(WINDOW_MAX);
   localparam logic [OW-1:0]       OCC_FULL  = OW'(WINDOW_MAX);
   localparam logic [SW-1:0]       DEPTH_SUM = SW'(WINDOW_MAX);
   localparam logic [AW-1:0]       LAST_IDX  = AW'(WINDOW_MAX - 1);

   logic [CFG_BITS-1:0]    wsize_ff, wsize_in;
   logic [AW-1:0]          head_ff, head_in;
   logic [OW-1:0]          occ_ff, occ_in;
   logic [OW-1:0]          fill_ff, fill_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;
   logic [SAMPLE_BITS-1:0] samp_ff, samp_in;
   logic                   end_ff, end_in;
   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] out_data_ff, out_data_in;
   logic                   out_last_ff, out_last_in;

   logic [POS_BITS-1:0]    ws_pos;
   logic [POS_BITS-1:0]    win_k;
   logic [SW-1:0]          sum;
   logic [SW-1:0]          tail_sum;
   logic [AW-1:0]          tail_idx;
   logic [AW-1:0]          back_idx;
   logic [AW-1:0]          head_inc;
   logic [AW-1:0]          rd_addr;
   logic [EW-1:0]          rd_data;
   logic [SAMPLE_BITS-1:0] rd_val;
   logic [POS_BITS-1:0]    rd_pos;
   logic [POS_BITS-1:0]    age;

   // effective window: zero acts as one, large values clamp to the depth
   assign ws_pos = POS_BITS'(wsize_ff);
   assign win_k  = (wsize_ff == '0) ? POS_BITS'(1)
                 : ((ws_pos > WMAX_POS) ? WMAX_POS : ws_pos);

   // circular buffer indexes
   assign sum      = SW'(head_ff) + SW'(occ_ff);
   assign tail_sum = (sum >= DEPTH_SUM) ? (sum - DEPTH_SUM) : sum;
   assign tail_idx = tail_sum[AW-1:0];
   assign back_idx = (tail_idx == '0) ? LAST_IDX : (tail_idx - AW'(1));
   assign head_inc = (head_ff == LAST_IDX) ? '0 : (head_ff + AW'(1));
   assign rd_addr  = cmd.rd_back ? back_idx : head_ff;

   swm_ram #(
      .WIDTH (EW),
      .DEPTH (WINDOW_MAX)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (tail_idx),
      .wr_data ({pos_ff, samp_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_val = rd_data[SAMPLE_BITS-1:0];
   assign rd_pos = rd_data[EW-1:SAMPLE_BITS];
   assign age    = pos_ff - rd_pos;

   assign status.queue_empty   = (occ_ff == '0);
   assign status.front_expired = (age >= win_k);
   assign status.back_le       = ($signed(rd_val) <= $signed(samp_ff));
   assign status.result_due    = (POS_BITS'(fill_ff) >= win_k);
   assign status.out_free      = !out_valid_ff || rsp_tready;

   always_comb begin
      wsize_in     = csr_wr_en ? csr_wr_data : wsize_ff;
      head_in      = head_ff;
      occ_in       = occ_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      samp_in      = samp_ff;
      end_in       = end_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;

      if (cmd.take) begin
         samp_in = req_sample;
         end_in  = req_end;
         if (req_start) begin
            occ_in  = '0;
            fill_in = '0;
         end
      end
      if (cmd.drop_front) begin
         head_in = head_inc;
         occ_in  = occ_ff - OW'(1);
      end
      if (cmd.drop_back) begin
         occ_in = occ_ff - OW'(1);
      end
      if (cmd.push) begin
         // a full queue loses its front entry; the write lands in its slot
         if (occ_ff == OCC_FULL) begin
            head_in = head_inc;
         end else begin
            occ_in = occ_ff + OW'(1);
         end
         pos_in = pos_ff + POS_BITS'(1);
         if (fill_ff < OCC_FULL) begin
            fill_in = fill_ff + OW'(1);
         end
      end

      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_data_in  = rd_val;
         out_last_in  = end_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wsize_ff     <= WINDOW_SIZE_RESET;
         head_ff      <= '0;
         occ_ff       <= '0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wsize_ff     <= wsize_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      samp_ff     <= samp_in;
      end_ff      <= end_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_sample = out_data_ff;
   assign rsp_last   = out_last_ff;

   `SWM_ASSERT_IMPL(a_occ_bound, clock, reset, 1'b1, occ_ff <= OCC_FULL)
   `SWM_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, fill_ff <= OCC_FULL)
   `SWM_ASSERT_IMPL(a_pop_nonempty, clock, reset, cmd.drop_back || cmd.drop_front, occ_ff != '0)
   `SWM_ASSERT_IMPL(a_load_free, clock, reset, cmd.load_out, !out_valid_ff || rsp_tready)
   `SWM_ASSERT_NEXT(a_start_clears, clock, reset, cmd.take && req_start, occ_ff == '0 && fill_ff == '0)

endmodule

### src/sliding_window_maximum_core.sv
// ----------------------------------------------------------------------------
// sliding_window_maximum_core
// streaming maximum over the last window_size signed samples, kept as a
// monotonic queue of candidate maxima in a circular buffer
// ----------------------------------------------------------------------------
//  channel   direction  fields (tdata low bit up / tuser / tlast)
//  req_      in         sample                / start_new / end_flag
//  rsp_      out        window_max            / -         / last_window
//  csr_      in         window_size (write only, one register)
//
//  one sample at a time; the queue ram has a single read port, so each
//  transaction reads and tests one entry at a time as it expires and pops.
//  the next sample is taken while a result still waits in the output register.
//  reset is synchronous and active high; it empties the queue, clears the
//  position and fill count, and sets window_size to one.
//  a stalled rsp_ side holds the block only when a second result is ready.
// ----------------------------------------------------------------------------
module sliding_window_maximum_core #(
   parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEFAULT,
   localparam int DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [swm_pkg::CFG_BITS-1:0] csr_wr_data,   // window_size
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [DATA_BITS-1:0]         req_tdata,     // sample
   input  logic                         req_tuser,     // start_new
   input  logic                         req_tlast,     // end_flag
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [DATA_BITS-1:0]         rsp_tdata,     // window_max
   output logic                         rsp_tlast      // last_window
);

   import swm_pkg::*;

   swm_cmd_type            cmd;
   swm_status_type         status;
   logic [SAMPLE_BITS-1:0] rsp_sample;

   swm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   swm_dp #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_sample  (req_tdata[SAMPLE_BITS-1:0]),
      .req_start   (req_tuser),
      .req_end     (req_tlast),
      .rsp_tready  (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_sample  (rsp_sample),
      .rsp_last    (rsp_tlast),
      .cmd         (cmd),
      .status      (status)
   );

   assign rsp_tdata = DATA_BITS'(rsp_sample);

endmodule
